>>> src/argb_pixel_blend_convert_core_defines.svh
// Assertion macros for the ARGB pixel blend and conversion core.
`ifndef ARGB_PIXEL_BLEND_CONVERT_CORE_DEFINES_SVH
`define ARGB_PIXEL_BLEND_CONVERT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define APBC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define APBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define APBC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define APBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> src/apbc_pkg.sv
// Shared types and constants of the ARGB pixel blend and conversion core.
`timescale 1ns / 1ps

package apbc_pkg;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned PIX_W   = 32;
    localparam int unsigned OP_W    = 3;

    // Register indexes on the configuration port.
    localparam logic REG_PIXEL_OP = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_COPY       = 3'd0,
        OP_BLEND_ARGB = 3'd1,
        OP_BLEND_RGB  = 3'd2,
        OP_DROP_ALPHA = 3'd3,
        OP_RGB565     = 3'd4,
        OP_RGB332     = 3'd5,
        OP_RGB2220    = 3'd6,
        OP_LUMA       = 3'd7
    } t_pixel_op;

endpackage

>>> src/apbc_regs.sv
// APB configuration register block holding the pixel operation.
`timescale 1ns / 1ps

module apbc_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [apbc_pkg::PADDR_W-1:0]   paddr,
    input  logic [apbc_pkg::PDATA_W-1:0]   pwdata,
    output logic [apbc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output apbc_pkg::t_pixel_op            o_pixel_op
);
    import apbc_pkg::*;

    t_pixel_op r_pixel_op;
    logic      reg_idx;
    logic      wr_en;

    assign reg_idx = paddr[PADDR_W-1];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_op <= OP_COPY;
        end else if (wr_en && (reg_idx == REG_PIXEL_OP)) begin
            r_pixel_op <= t_pixel_op'(pwdata[OP_W-1:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_PIXEL_OP) begin
            prdata[OP_W-1:0] = r_pixel_op;
        end
    end

    assign o_pixel_op = r_pixel_op;

endmodule

>>> src/apbc_pixel_alu.sv
// Combinational pixel operation: alpha blend, alpha drop and format conversion.
`timescale 1ns / 1ps

module apbc_pixel_alu (
    input  apbc_pkg::t_pixel_op            i_op,
    input  logic [apbc_pkg::PIX_W-1:0]     i_src,
    input  logic [apbc_pkg::PIX_W-1:0]     i_dest,
    output logic [apbc_pkg::PIX_W-1:0]     o_pixel
);
    import apbc_pkg::*;

    localparam logic [7:0] LUMA_R  = 8'd218;
    localparam logic [9:0] LUMA_G  = 10'd732;
    localparam logic [6:0] LUMA_B  = 7'd74;
    localparam logic [7:0] A_OPAQUE = 8'd255;

    logic [7:0]       alpha;
    logic [7:0]       a_w;
    logic [7:0]       ai_w;
    logic [PIX_W-1:0] blend;
    logic [15:0]      s_term [3];
    logic [15:0]      d_term [3];
    logic [8:0]       ch_sum [3];
    logic [17:0]      luma_sum;

    assign alpha = i_src[31:24];
    // Alpha is between 1 and 254 whenever the weighted mix is used.
    assign a_w   = alpha + 8'd1;
    assign ai_w  = A_OPAQUE - a_w;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s_term[c] = 16'(i_src[8*c +: 8]) * 16'(a_w);
            d_term[c] = 16'(i_dest[8*c +: 8]) * 16'(ai_w);
            ch_sum[c] = {1'b0, s_term[c][15:8]} + {1'b0, d_term[c][15:8]};
        end
        priority if (alpha == 8'd0) begin
            blend = i_dest;
        end else if (alpha == A_OPAQUE) begin
            blend = i_src;
        end else begin
            blend = {a_w, ch_sum[2][7:0], ch_sum[1][7:0], ch_sum[0][7:0]};
        end
    end

    assign luma_sum = (18'(i_src[23:16]) * 18'(LUMA_R)) + (18'(i_src[15:8]) * 18'(LUMA_G))
                    + (18'(i_src[7:0]) * 18'(LUMA_B));

    always_comb begin
        o_pixel = '0;
        unique case (i_op)
            OP_COPY:       o_pixel = i_src;
            OP_BLEND_ARGB: o_pixel = blend;
            OP_BLEND_RGB:  o_pixel[23:0] = blend[23:0];
            OP_DROP_ALPHA: o_pixel[23:0] = i_src[23:0];
            OP_RGB565:     o_pixel[15:0] = {i_src[23:19], i_src[15:10], i_src[7:3]};
            OP_RGB332:     o_pixel[7:0]  = {i_src[23:21], i_src[15:13], i_src[7:6]};
            OP_RGB2220:    o_pixel[7:0]  = {i_src[23:22], i_src[15:14], i_src[7:6], 2'b00};
            OP_LUMA:       o_pixel[7:0]  = luma_sum[17:10];
            default:       o_pixel = '0;
        endcase
    end

endmodule

>>> src/argb_pixel_blend_convert_core.sv
// Top level of the ARGB pixel blend and conversion core.
`timescale 1ns / 1ps
`include "argb_pixel_blend_convert_core_defines.svh"

// The core takes one pixel per clock: a transfer happens whenever start is high,
// and busy is never raised. Each pixel is caught in one input register, goes
// through a single combinational stage and is caught in one result register,
// and is then shown for exactly one cycle with o_valid high; the receiver
// must take it then, since it cannot stall the core. The operation is sampled
// with the pixel, so pixel_op should be written only while no pixel is in flight.
module argb_pixel_blend_convert_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [apbc_pkg::PADDR_W-1:0]   paddr,
    input  logic [apbc_pkg::PDATA_W-1:0]   pwdata,
    output logic [apbc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic [apbc_pkg::PIX_W-1:0]     i_src_pixel,
    input  logic [apbc_pkg::PIX_W-1:0]     i_dest_pixel,
    output logic                           o_valid,
    output logic [apbc_pkg::PIX_W-1:0]     o_out_pixel
);
    import apbc_pkg::*;

    t_pixel_op        pixel_op;
    logic             in_xfer;
    logic             r_in_vld;
    t_pixel_op        r_op;
    logic [PIX_W-1:0] r_src;
    logic [PIX_W-1:0] r_dest;
    logic [PIX_W-1:0] n_out_pixel;
    logic             r_out_vld;
    logic [PIX_W-1:0] r_out_pixel;

    apbc_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_pixel_op (pixel_op)
    );

    assign busy    = 1'b0;
    assign in_xfer = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op   <= pixel_op;
            r_src  <= i_src_pixel;
            r_dest <= i_dest_pixel;
        end
    end

    apbc_pixel_alu u_alu (
        .i_op    (r_op),
        .i_src   (r_src),
        .i_dest  (r_dest),
        .o_pixel (n_out_pixel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_out_pixel <= n_out_pixel;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_out_pixel = r_out_pixel;

    `APBC_ASSERT_NEXT(a_xfer_reaches_stage, i_clk, i_rst_n, in_xfer, r_in_vld,
                      "transfer lost in input stage")
    `APBC_ASSERT_NEXT(a_stage_to_result, i_clk, i_rst_n, r_in_vld, o_valid,
                      "staged pixel produced no result")
    `APBC_ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, !r_in_vld, !o_valid,
                      "result strobe without a staged pixel")
    `APBC_ASSERT_NEXT(a_copy_exact, i_clk, i_rst_n, r_in_vld && (r_op == OP_COPY),
                      o_out_pixel == $past(r_src), "copy result differs from source")
    `APBC_ASSERT_NEXT(a_narrow_zero, i_clk, i_rst_n,
                      r_in_vld && (r_op == OP_RGB565 || r_op == OP_RGB332 ||
                                   r_op == OP_RGB2220 || r_op == OP_LUMA),
                      o_out_pixel[31:16] == 16'd0, "narrow format has upper bits set")

endmodule

>>> tb/sv/tb_argb_pixel_blend_convert_core.sv
// Self-checking testbench of the ARGB pixel blend and conversion core.
`timescale 1ns / 1ps

module tb_argb_pixel_blend_convert_core;

    import apbc_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_PIXEL_OP = {REG_PIXEL_OP, 2'b00};
    // Word slot right after pixel_op; no register lives there.
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
    localparam int unsigned        SETTLE_CYCLES = 4;
    localparam int unsigned        CYCLE_LIMIT   = 200000;
    localparam int unsigned        ITEMS_PER_OP  = 33;

    // Predicts the output pixel of every accepted transfer and checks results in order.
    class pixel_scoreboard;
        logic [PIX_W-1:0] expected_pixels[$];
        int unsigned      failures;

        function new();
            failures = 0;
        endfunction

        // A mixed blend ignores destination alpha; its alpha is source alpha plus one.
        function automatic logic [PIX_W-1:0] blend(logic [PIX_W-1:0] d, logic [PIX_W-1:0] s);
            int unsigned      a;
            int unsigned      ai;
            int unsigned      c;
            logic [PIX_W-1:0] res;
            if (s[31:24] == 8'h00) return d;
            if (s[31:24] == 8'hff) return s;
            a   = s[31:24] + 1;
            ai  = 255 - a;
            res = {a[7:0], 24'h0};
            for (int sh = 0; sh < 24; sh += 8) begin
                c = (32'(s[sh +: 8]) * a) / 256 + (32'(d[sh +: 8]) * ai) / 256;
                res[sh +: 8] = c[7:0];
            end
            return res;
        endfunction

        function automatic logic [PIX_W-1:0] predict_pixel(t_pixel_op op,
                                                           logic [PIX_W-1:0] s,
                                                           logic [PIX_W-1:0] d);
            int unsigned      luma;
            logic [PIX_W-1:0] rgb_blend;
            rgb_blend = blend({8'hff, d[23:0]}, s);
            case (op)
                OP_COPY:       return s;
                OP_BLEND_ARGB: return blend(d, s);
                OP_BLEND_RGB:  return {8'h00, rgb_blend[23:0]};
                OP_DROP_ALPHA: return {8'h00, s[23:0]};
                OP_RGB565:     return {16'h0, s[23:19], s[15:10], s[7:3]};
                OP_RGB332:     return {24'h0, s[23:21], s[15:13], s[7:6]};
                OP_RGB2220:    return {24'h0, s[23:22], s[15:14], s[7:6], 2'b00};
                default: begin
                    luma = (218 * 32'(s[23:16]) + 732 * 32'(s[15:8]) + 74 * 32'(s[7:0])) >> 10;
                    return {24'h0, luma[7:0]};
                end
            endcase
        endfunction

        function void note_pixel(t_pixel_op op, logic [PIX_W-1:0] s, logic [PIX_W-1:0] d);
            expected_pixels.push_back(predict_pixel(op, s, d));
        endfunction

        function void check_pixel(logic [PIX_W-1:0] actual);
            logic [PIX_W-1:0] want;
            if (expected_pixels.size() == 0) begin
                $error("out_pixel with no transfer pending: actual %08h", actual);
                failures++;
                return;
            end
            want = expected_pixels.pop_front();
            if (actual !== want) begin
                $error("out_pixel mismatch: expected %08h, actual %08h", want, actual);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [PDATA_W-1:0] pwdata       = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               start        = 1'b0;
    logic               busy;
    logic [PIX_W-1:0]   i_src_pixel  = '0;
    logic [PIX_W-1:0]   i_dest_pixel = '0;
    logic               o_valid;
    logic [PIX_W-1:0]   o_out_pixel;

    pixel_scoreboard sb = new();
    t_pixel_op       op_shadow = OP_COPY;
    int unsigned     idle_pct  = 0;
    int unsigned     cycle_count = 0;

    argb_pixel_blend_convert_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .i_src_pixel  (i_src_pixel),
        .i_dest_pixel (i_dest_pixel),
        .o_valid      (o_valid),
        .o_out_pixel  (o_out_pixel)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_pixel(op_shadow, i_src_pixel, i_dest_pixel);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_pixel(o_out_pixel);
    end

    // Alpha leans toward the opaque, transparent and near-edge values that switch the blend.
    function automatic logic [PIX_W-1:0] random_argb();
        logic [PIX_W-1:0] p;
        p = $urandom();
        case ($urandom_range(7))
            0: p[31:24] = 8'h00;
            1: p[31:24] = 8'hff;
            2: p[31:24] = $urandom_range(1) ? 8'h01 : 8'hfe;
            default: ;
        endcase
        case ($urandom_range(7))
            0: p[23:0] = 24'hffffff;
            1: p[23:0] = 24'h000000;
            default: ;
        endcase
        return p;
    endfunction

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes pixel_op with junk in the upper bits, then reads it back.
    task automatic set_pixel_op(t_pixel_op op);
        logic [PDATA_W-1:0] data;
        data = $urandom();
        data[OP_W-1:0] = op;
        wait_idle();
        apb_write(ADDR_PIXEL_OP, data);
        op_shadow = op;
        psel    <= 1'b1;
        paddr   <= ADDR_PIXEL_OP;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[OP_W-1:0] !== op) begin
            $error("pixel_op mismatch: expected %0d, actual %0d", op, prdata[OP_W-1:0]);
            sb.failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] s, logic [PIX_W-1:0] d);
        if ($urandom_range(99) < idle_pct) begin
            start        <= 1'b0;
            i_src_pixel  <= $urandom();
            i_dest_pixel <= $urandom();
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_src_pixel  <= s;
        i_dest_pixel <= d;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_extremes();
        send_pixel(32'h0000_0000, 32'hffff_ffff);
        send_pixel(32'hffff_ffff, 32'h0000_0000);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part; the first pixels run on the reset value of pixel_op.
        send_extremes();
        start <= 1'b0;
        wait_idle();
        // A write to the empty slot must leave the copy operation in place.
        apb_write(ADDR_UNMAPPED, 32'hffff_ffff);
        send_pixel(32'h8012_3456, 32'h00ab_cdef);
        for (int k = 1; k < 8; k++) begin
            start <= 1'b0;
            set_pixel_op(t_pixel_op'(k));
            send_extremes();
            if (t_pixel_op'(k) == OP_BLEND_ARGB) begin
                send_pixel(32'h0012_3456, 32'ha5a5_a5a5);
                send_pixel(32'hff12_3456, 32'ha5a5_a5a5);
                send_pixel(32'h01ff_ffff, 32'h00ff_ffff);
                send_pixel(32'hfeff_ffff, 32'hffff_ffff);
            end
            if (t_pixel_op'(k) == OP_BLEND_RGB) begin
                send_pixel(32'h0012_3456, 32'h5a65_4321);
                send_pixel(32'h80ff_00ff, 32'hc000_ff00);
            end
        end

        // Random part: every operation under each sender idling pattern.
        for (int phase = 0; phase < 3; phase++) begin
            for (int k = 0; k < 8; k++) begin
                start <= 1'b0;
                set_pixel_op(t_pixel_op'(k));
                idle_pct = (phase == 0) ? 0 : (phase == 1) ? 73 : 29;
                repeat (ITEMS_PER_OP) send_pixel(random_argb(), $urandom());
                idle_pct = 0;
            end
        end

        start <= 1'b0;
        wait_idle();
        if (sb.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/apbc_pkg.sv
src/apbc_regs.sv
src/apbc_pixel_alu.sv
src/argb_pixel_blend_convert_core.sv
tb/sv/tb_argb_pixel_blend_convert_core.sv
